// ===== design/timestamped_trail_delay_interpolator_core_assert.svh =====
// Assertion macros for the trail delay interpolator core.
`ifndef TIMESTAMPED_TRAIL_DELAY_INTERPOLATOR_CORE_ASSERT_SVH
`define TIMESTAMPED_TRAIL_DELAY_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under the synchronous reset.
`define TTDI_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication under the synchronous reset.
`define TTDI_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TTDI_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TTDI_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== design/ttdi_pkg.sv =====
// Shared constants for the trail delay interpolator core.
`timescale 1ns / 1ps
package ttdi_pkg;
  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int MAX_FOLLOWERS_DEF = 4;

  localparam int POS_W  = 24;
  localparam int AGE_W  = 24;
  localparam int DT_W   = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_FOLLOW_SPACING = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DELAY_STEP     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FOLLOWER_COUNT = 2'd2;

  localparam logic [15:0] SPACING_RST = 16'd5120;
  localparam logic [15:0] STEP_RST    = 16'd3277;
  localparam logic [2:0]  COUNT_RST   = 3'd3;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
endpackage

// ===== design/timestamped_trail_delay_interpolator_core.sv =====
// Top level of the trail delay interpolator core.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | leader position, time, facing, scale
//  out_    | output    | out_valid/out_stall| follow order, target x/y, last flag
//  cfg_    | input     | cfg_we             | register index and data
//
// A tick ages each held entry (AGEA, AGEB) and inserts the new word (INS);
// then, for each follow order, it walks the trail (FST, then WA and WB per
// entry visited, at most the entries held) and, when interpolating, runs the
// shared restoring divider (MUL, DIV, FIN) for x and then y, before the hand-off
// (EMIT, HOLD). The one trail RAM read port is registered; the divider is bit-serial. No clearing
// pass: the fill count guards the trail. in_stall stays high while a tick is in
// work; a stalled result word holds and the sequencer waits on it.
`timescale 1ns / 1ps
`include "timestamped_trail_delay_interpolator_core_assert.svh"
module timestamped_trail_delay_interpolator_core
  import ttdi_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int MAX_FOLLOWERS = MAX_FOLLOWERS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_leader_x,
  input  logic signed [POS_W-1:0] in_leader_y,
  input  logic [DT_W-1:0]         in_elapsed_time,
  input  logic signed [1:0]       in_facing,
  input  logic [11:0]             in_leader_scale,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_follow_order,
  output logic signed [POS_W-1:0] out_target_x,
  output logic signed [POS_W-1:0] out_target_y,
  output logic                    out_last_of_run,
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int KW   = $clog2(MAX_FOLLOWERS + 1);
  localparam int DLW  = 16 + KW;
  localparam int OW   = 21 + KW;
  localparam int SW   = OW + 2;
  localparam int EW   = 2 * POS_W + AGE_W;
  localparam int DVW  = 50;
  localparam int CNTW = 6;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AGEA = 4'd1;
  localparam logic [3:0] S_AGEB = 4'd2;
  localparam logic [3:0] S_INS  = 4'd3;
  localparam logic [3:0] S_FST  = 4'd4;
  localparam logic [3:0] S_WA   = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;
  localparam logic [3:0] S_HOLD = 4'd11;

  // configuration registers
  logic [15:0] spacing_r;
  logic [15:0] step_r;
  logic [2:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
      step_r    <= STEP_RST;
      count_r   <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOLLOW_SPACING: spacing_r <= cfg_wdata;
        REG_DELAY_STEP:     step_r    <= cfg_wdata;
        REG_FOLLOWER_COUNT: count_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // control and payload registers
  logic [3:0]              state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic [FW-1:0]           idx_r, idx_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic [KW-1:0]           n_r, n_nxt;
  logic [DLW-1:0]          delay_r, delay_nxt;
  logic [OW-1:0]           off_r, off_nxt;
  logic [20:0]             gap_r, gap_nxt;
  logic signed [POS_W-1:0] lx_r, lx_nxt, ly_r, ly_nxt;
  logic [DT_W-1:0]         dt_r, dt_nxt;
  logic [1:0]              dir_r, dir_nxt;
  logic [EW-1:0]           prev_r, prev_nxt, cur_r, cur_nxt;
  logic [AGE_W-1:0]        num_r, num_nxt, den_r, den_nxt;
  logic                    ysel_r, ysel_nxt;
  logic                    neg_r, neg_nxt;
  logic [DVW-1:0]          q_r, q_nxt;
  logic [AGE_W:0]          rem_r, rem_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                    ov_r, ov_nxt;
  logic [2:0]              ofo_r, ofo_nxt;
  logic signed [POS_W-1:0] otx_r, otx_nxt, oty_r, oty_nxt;
  logic                    olast_r, olast_nxt;

  // trail RAM: {x, y, age}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  ttdi_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_trail (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // first gap from spacing and scale
  logic [28:0] gap_prod;
  assign gap_prod = {13'd0, spacing_r} * {17'd0, in_leader_scale} + 29'd128;

  // follower count clamp
  logic [KW+2:0] count_x;
  assign count_x = {{KW{1'b0}}, count_r};

  // pointer steps around the ring
  logic [AW-1:0] ptr_dec, head_inc;
  assign ptr_dec  = (ptr_r == '0) ? AW'(HISTORY_DEPTH - 1) : ptr_r - AW'(1);
  assign head_inc = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + AW'(1);

  // entry fields
  logic [AGE_W-1:0] rd_age, prev_age;
  logic [AGE_W:0]   aged_sum;
  logic [AGE_W-1:0] delay_x;
  assign rd_age   = ram_rdata[AGE_W-1:0];
  assign prev_age = prev_r[AGE_W-1:0];
  assign aged_sum = {1'b0, rd_age} + {{(AGE_W + 1 - DT_W){1'b0}}, dt_r};
  assign delay_x  = {{(AGE_W - DLW){1'b0}}, delay_r};

  // interpolation operands
  logic signed [POS_W-1:0] op_a, op_b;
  logic signed [POS_W:0]   diff;
  logic [POS_W:0]          diff_mag;
  logic [48:0]             mag;
  assign op_a     = ysel_r ? prev_r[AGE_W +: POS_W] : prev_r[AGE_W+POS_W +: POS_W];
  assign op_b     = ysel_r ? cur_r[AGE_W +: POS_W]  : cur_r[AGE_W+POS_W +: POS_W];
  assign diff     = {op_b[POS_W-1], op_b} - {op_a[POS_W-1], op_a};
  assign diff_mag = diff[POS_W] ? (POS_W+1)'(0) - diff : diff;
  assign mag      = diff_mag * num_r;

  // divider step
  logic [AGE_W:0] trial;
  logic           fits;
  assign trial = {rem_r[AGE_W-1:0], q_r[DVW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // lerp result
  logic signed [POS_W+1:0] lerp;
  assign lerp = neg_r ? {{2{op_a[POS_W-1]}}, op_a} - {1'b0, q_r[POS_W:0]}
                      : {{2{op_a[POS_W-1]}}, op_a} + {1'b0, q_r[POS_W:0]};

  // target x with gap offset, saturated
  logic signed [SW-1:0] tx_sum;
  logic signed [SW-1:0] px_x, off_x;
  logic signed [POS_W-1:0] tx_sat;
  assign px_x  = {{(SW-POS_W){px_r[POS_W-1]}}, px_r};
  assign off_x = {2'b00, off_r};
  always_comb begin
    case (dir_r)
      2'b01:   tx_sum = px_x - off_x;
      2'b11:   tx_sum = px_x + off_x;
      default: tx_sum = px_x;
    endcase
    if (tx_sum > SW'(8388607)) begin
      tx_sat = POS_W'(8388607);
    end else if (tx_sum < -SW'(8388608)) begin
      tx_sat = -POS_W'(8388608);
    end else begin
      tx_sat = tx_sum[POS_W-1:0];
    end
  end

  logic [KW+2:0] k_x;
  assign k_x = {3'b000, k_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    delay_nxt = delay_r;
    off_nxt   = off_r;
    gap_nxt   = gap_r;
    lx_nxt    = lx_r;
    ly_nxt    = ly_r;
    dt_nxt    = dt_r;
    dir_nxt   = dir_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    ysel_nxt  = ysel_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ov_nxt    = ov_r;
    ofo_nxt   = ofo_r;
    otx_nxt   = otx_r;
    oty_nxt   = oty_r;
    olast_nxt = olast_r;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ram_rdata;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lx_nxt  = in_leader_x;
          ly_nxt  = in_leader_y;
          dt_nxt  = in_elapsed_time;
          dir_nxt = (in_facing == 2'sb01) ? 2'b01 : (in_facing[1] ? 2'b11 : 2'b00);
          gap_nxt = gap_prod[28:8];
          n_nxt   = (count_x > (KW+3)'(MAX_FOLLOWERS)) ? KW'(MAX_FOLLOWERS) : count_x[KW-1:0];
          ptr_nxt = head_r;
          idx_nxt = '0;
          state_nxt = (fill_r == '0) ? S_INS : S_AGEA;
        end
      end
      S_AGEA: begin
        state_nxt = S_AGEB;
      end
      S_AGEB: begin
        // age one entry, saturating
        ram_we    = 1'b1;
        ram_wdata = {ram_rdata[EW-1:AGE_W], aged_sum[AGE_W] ? AGE_MAX : aged_sum[AGE_W-1:0]};
        ptr_nxt   = ptr_dec;
        idx_nxt   = idx_r + FW'(1);
        state_nxt = (idx_r + FW'(1) == fill_r) ? S_INS : S_AGEA;
      end
      S_INS: begin
        // push the new word at age zero
        ram_we    = 1'b1;
        ram_waddr = head_inc;
        ram_wdata = {lx_r, ly_r, {AGE_W{1'b0}}};
        head_nxt  = head_inc;
        if (fill_r != FW'(HISTORY_DEPTH)) begin
          fill_nxt = fill_r + FW'(1);
        end
        k_nxt     = KW'(1);
        delay_nxt = {{KW{1'b0}}, step_r};
        off_nxt   = '0;
        state_nxt = (n_r == '0) ? S_IDLE : S_FST;
      end
      S_FST: begin
        if (delay_r == '0) begin
          px_nxt    = lx_r;
          py_nxt    = ly_r;
          state_nxt = S_EMIT;
        end else begin
          ptr_nxt   = head_r;
          idx_nxt   = '0;
          state_nxt = S_WA;
        end
      end
      S_WA: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (idx_r == '0) begin
          prev_nxt = ram_rdata;
          if (fill_r == FW'(1)) begin
            px_nxt    = ram_rdata[AGE_W+POS_W +: POS_W];
            py_nxt    = ram_rdata[AGE_W +: POS_W];
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = FW'(1);
            ptr_nxt   = ptr_dec;
            state_nxt = S_WA;
          end
        end else if (rd_age >= delay_x) begin
          cur_nxt = ram_rdata;
          if (rd_age > prev_age && delay_x > prev_age) begin
            num_nxt   = delay_x - prev_age;
            den_nxt   = rd_age - prev_age;
            ysel_nxt  = 1'b0;
            state_nxt = S_MUL;
          end else begin
            px_nxt    = prev_r[AGE_W+POS_W +: POS_W];
            py_nxt    = prev_r[AGE_W +: POS_W];
            state_nxt = S_EMIT;
          end
        end else if (idx_r + FW'(1) == fill_r) begin
          px_nxt    = ram_rdata[AGE_W+POS_W +: POS_W];
          py_nxt    = ram_rdata[AGE_W +: POS_W];
          state_nxt = S_EMIT;
        end else begin
          prev_nxt  = ram_rdata;
          idx_nxt   = idx_r + FW'(1);
          ptr_nxt   = ptr_dec;
          state_nxt = S_WA;
        end
      end
      S_MUL: begin
        // load the rounded dividend
        neg_nxt   = diff[POS_W];
        q_nxt     = {1'b0, mag} + {{(DVW-AGE_W+1){1'b0}}, den_r[AGE_W-1:1]};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = fits ? trial - {1'b0, den_r} : trial;
        q_nxt   = {q_r[DVW-2:0], fits};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(DVW - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ysel_r) begin
          px_nxt    = lerp[POS_W-1:0];
          ysel_nxt  = 1'b1;
          state_nxt = S_MUL;
        end else begin
          py_nxt    = lerp[POS_W-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        ov_nxt    = 1'b1;
        ofo_nxt   = k_x[2:0];
        otx_nxt   = tx_sat;
        oty_nxt   = py_r;
        olast_nxt = (k_r == n_r);
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // wait for the result word to be taken, then advance the order
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (k_r == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            off_nxt   = (k_r == KW'(1)) ? {{KW{1'b0}}, gap_r}
                                        : off_r + {{(OW-16){1'b0}}, spacing_r};
            k_nxt     = k_r + KW'(1);
            delay_nxt = delay_r + {{KW{1'b0}}, step_r};
            state_nxt = S_FST;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    delay_r <= delay_nxt;
    off_r   <= off_nxt;
    gap_r   <= gap_nxt;
    lx_r    <= lx_nxt;
    ly_r    <= ly_nxt;
    dt_r    <= dt_nxt;
    dir_r   <= dir_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    ysel_r  <= ysel_nxt;
    neg_r   <= neg_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    ofo_r   <= ofo_nxt;
    otx_r   <= otx_nxt;
    oty_r   <= oty_nxt;
    olast_r <= olast_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_follow_order = ofo_r;
  assign out_target_x     = otx_r;
  assign out_target_y     = oty_r;
  assign out_last_of_run  = olast_r;

  // checks
  `TTDI_ASSERT_IMP(a_idle_no_result, clk, rst_n, !in_stall, !out_valid)
  `TTDI_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(HISTORY_DEPTH))
  `TTDI_ASSERT_IMP(a_order_nonzero, clk, rst_n, out_valid, k_r != '0 && k_r <= n_r)
  `TTDI_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

// ===== design/ttdi_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ttdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sv/tb_timestamped_trail_delay_interpolator_core.sv =====
// Self-checking testbench for the trail delay interpolator core.
`timescale 1ns / 1ps
module tb_timestamped_trail_delay_interpolator_core;
  import ttdi_pkg::*;

  localparam int DEPTH      = HISTORY_DEPTH_DEF;
  localparam int MAX_F      = MAX_FOLLOWERS_DEF;
  // worst tick: ageing plus four walks and divides, with margin
  localparam int SETTLE     = 1500;
  localparam int IDLE_LIMIT = 20000;
  localparam longint S24_MAX = 64'sd8388607;
  localparam longint S24_MIN = -64'sd8388608;

  typedef struct {
    logic [2:0]        order;
    logic [POS_W-1:0]  tx;
    logic [POS_W-1:0]  ty;
    logic              last;
  } target_t;

  // Follower target predictor and store of pending targets
  class trail_scoreboard;
    longint      hist_x[DEPTH];
    longint      hist_y[DEPTH];
    longint      hist_age[DEPTH];
    int          fill;
    longint      spacing, step, count;
    target_t     pending[$];
    int          errors;

    function new();
      fill = 0;
      spacing = SPACING_RST;
      step = STEP_RST;
      count = COUNT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FOLLOW_SPACING: spacing = v;
        REG_DELAY_STEP:     step = v;
        REG_FOLLOWER_COUNT: count = v[2:0];
        default: ;
      endcase
    endfunction

    function longint sat24(longint v);
      if (v > S24_MAX) return S24_MAX;
      if (v < S24_MIN) return S24_MIN;
      return v;
    endfunction

    // a + (b - a) * num / den, nearest with halves away from zero
    function longint blend(longint a, longint b, longint num, longint den);
      longint diff, mag, q;
      diff = b - a;
      mag = (diff < 0 ? -diff : diff) * num;
      q = (mag + den / 2) / den;
      return sat24(diff < 0 ? a - q : a + q);
    endfunction

    function void lookup(longint cx, longint cy, longint delay,
                         output longint ox, output longint oy);
      longint older, newer;
      ox = cx;
      oy = cy;
      if (fill == 0 || delay == 0) return;
      for (int i = 1; i < fill; i++) begin
        older = hist_age[i];
        if (older >= delay) begin
          newer = hist_age[i-1];
          if (older > newer && delay > newer) begin
            ox = blend(hist_x[i-1], hist_x[i], delay - newer, older - newer);
            oy = blend(hist_y[i-1], hist_y[i], delay - newer, older - newer);
          end else begin
            ox = hist_x[i-1];
            oy = hist_y[i-1];
          end
          return;
        end
      end
      ox = hist_x[fill-1];
      oy = hist_y[fill-1];
    endfunction

    function void note_tick(logic signed [POS_W-1:0] lx, logic signed [POS_W-1:0] ly,
                            logic [DT_W-1:0] dt, logic [1:0] face, logic [11:0] scale);
      longint dir, first_gap, offset, px, py, a;
      int n, top;
      target_t t;
      dir = (face == 2'b01) ? 1 : (face[1] ? -1 : 0);
      n = (count > MAX_F) ? MAX_F : int'(count);
      first_gap = (spacing * longint'(scale) + 128) >>> 8;
      // age the trail, then push the new position in at age zero
      for (int i = 0; i < fill; i++) begin
        a = hist_age[i] + dt;
        hist_age[i] = (a > longint'(AGE_MAX)) ? longint'(AGE_MAX) : a;
      end
      top = (fill >= DEPTH) ? DEPTH - 1 : fill;
      for (int i = top; i > 0; i--) begin
        hist_x[i] = hist_x[i-1];
        hist_y[i] = hist_y[i-1];
        hist_age[i] = hist_age[i-1];
      end
      hist_x[0] = lx;
      hist_y[0] = ly;
      hist_age[0] = 0;
      if (fill < DEPTH) fill++;
      for (int k = 1; k <= n; k++) begin
        lookup(lx, ly, k * step, px, py);
        offset = (k >= 2) ? first_gap + (k - 2) * spacing : 0;
        t.order = k[2:0];
        t.tx = POS_W'(sat24(px - offset * dir));
        t.ty = POS_W'(py);
        t.last = (k == n);
        pending.push_back(t);
      end
    endfunction

    function void check_target(target_t got);
      target_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word order=%0d x=%h y=%h last=%0d", $time,
                 got.order, got.tx, got.ty, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.order !== want.order) begin
        $display("%0t: follow_order expected %0d actual %0d", $time, want.order, got.order);
        errors++;
      end
      if (got.tx !== want.tx) begin
        $display("%0t: target_x expected %h actual %h", $time, want.tx, got.tx);
        errors++;
      end
      if (got.ty !== want.ty) begin
        $display("%0t: target_y expected %h actual %h", $time, want.ty, got.ty);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_leader_x = '0;
  logic signed [POS_W-1:0] in_leader_y = '0;
  logic [DT_W-1:0]         in_elapsed_time = '0;
  logic signed [1:0]       in_facing = '0;
  logic [11:0]             in_leader_scale = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [2:0]              out_follow_order;
  logic signed [POS_W-1:0] out_target_x;
  logic signed [POS_W-1:0] out_target_y;
  logic                    out_last_of_run;
  logic                    cfg_we = 1'b0;
  logic [CIDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  trail_scoreboard sb = new();
  bit calm = 1'b0;
  int idle_cycles = 0;
  logic signed [POS_W-1:0] walk_x = '0, walk_y = '0;

  timestamped_trail_delay_interpolator_core dut (.*);

  always #4 clk = ~clk;

  // Check each result word and stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_target('{out_follow_order, out_target_x, out_target_y, out_last_of_run});
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  // Count cycles without progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Write one register, then drop the enable
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Wait for every pending target, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_tick(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                           logic [DT_W-1:0] dt, logic [1:0] face, logic [11:0] scale);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_leader_x <= x;
    in_leader_y <= y;
    in_elapsed_time <= dt;
    in_facing <= face;
    in_leader_scale <= scale;
    do @(posedge clk); while (in_stall);
    sb.note_tick(x, y, dt, face, scale);
  endtask

  // Mostly a smooth walk with frame-like times; some full-range noise
  task automatic random_tick();
    logic [DT_W-1:0] dt;
    if ($urandom_range(99) < 80) begin
      walk_x = walk_x + $signed(24'($urandom_range(4096))) - 24'sd2048;
      walk_y = walk_y + $signed(24'($urandom_range(4096))) - 24'sd2048;
      dt = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(400, 5000));
      send_tick(walk_x, walk_y, dt, 2'($urandom_range(3)), 12'($urandom_range(200, 400)));
    end else begin
      send_tick(24'($urandom), 24'($urandom), 16'($urandom),
                2'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, every facing, zero and full elapsed time at reset values
    send_tick(24'sh7FFFFF, 24'sh800000, 16'd0,     2'b11, 12'd0);
    send_tick(24'sh800000, 24'sh7FFFFF, 16'd65535, 2'b01, 12'd4095);
    send_tick(24'sh7FFFFF, 24'sh7FFFFF, 16'd1000,  2'b11, 12'd4095);
    send_tick(24'sh800000, 24'sh800000, 16'd1000,  2'b01, 12'd4095);
    send_tick(24'sh7FFFFF, 24'sh000000, 16'd2000,  2'b10, 12'd256);
    send_tick(24'sh000000, 24'sh000000, 16'd0,     2'b00, 12'd256);
    send_tick(24'sh000100, 24'sh7FFF00, 16'd1638,  2'b01, 12'd128);
    send_tick(24'sh800000, 24'sh000100, 16'd3277,  2'b10, 12'd4095);
    send_tick(24'sh123456, 24'shEDCBA9, 16'd1,     2'b11, 12'd1);
    send_tick(24'sh7FFFFF, 24'sh800000, 16'd40000, 2'b11, 12'd4095);
    drain();

    // Zero delay, longest reach, then a count above the maximum
    write_reg(REG_FOLLOW_SPACING, 16'hFFFF);
    write_reg(REG_DELAY_STEP, 16'd0);
    write_reg(REG_FOLLOWER_COUNT, 16'd4);
    send_tick(24'sh7FFFFF, 24'sh800000, 16'd500, 2'b11, 12'd4095);
    send_tick(24'sh800000, 24'sh7FFFFF, 16'd500, 2'b01, 12'd4095);
    send_tick(24'sh000000, 24'sh000000, 16'd500, 2'b10, 12'd0);
    drain();
    write_reg(REG_DELAY_STEP, 16'hFFFF);
    write_reg(REG_FOLLOWER_COUNT, 16'd7);
    send_tick(24'sh7FFFFF, 24'sh000000, 16'd65535, 2'b10, 12'd4095);
    send_tick(24'sh800000, 24'sh000000, 16'd65535, 2'b01, 12'd4095);
    drain();

    // A count of zero gives no targets
    write_reg(REG_FOLLOWER_COUNT, 16'd0);
    write_reg(REG_FOLLOW_SPACING, 16'd0);
    repeat (4) random_tick();
    drain();

    // Random phases over a range of settings
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_FOLLOW_SPACING, (phase == 1) ? 16'd0 : 16'($urandom_range(0, 12000)));
      write_reg(REG_DELAY_STEP, (phase == 2) ? 16'd1 :
                (phase == 4) ? 16'd0 : 16'($urandom_range(800, 6000)));
      write_reg(REG_FOLLOWER_COUNT, (phase == 3) ? 16'd1 :
                (phase == 5) ? 16'd5 : 16'($urandom_range(1, 4)));
      calm = (phase == 3);
      repeat (60) random_tick();
      calm = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/ttdi_pkg.sv
design/ttdi_ram.sv
design/timestamped_trail_delay_interpolator_core.sv
tb/sv/tb_timestamped_trail_delay_interpolator_core.sv
